// ===== rtl/spdc_pkg.sv =====
// Package with the shared types, operation codes and constants of the distance cache.
package spdc_pkg;

    localparam int ENTRIES_DEFAULT = 8;

    localparam int SEG_W  = 15;
    localparam int LEN_W  = 16;
    localparam int DIST_W = 32;
    localparam int THR_W  = 31;

    localparam logic [1:0] KIND_FLUSH  = 2'd0;
    localparam logic [1:0] KIND_ADD    = 2'd1;
    localparam logic [1:0] KIND_LOOKUP = 2'd2;

    localparam logic [THR_W-1:0]  MIN_DIST_RESET = 31'd5242880;
    localparam logic [DIST_W-1:0] MISS_DISTANCE  = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [SEG_W-1:0] first_segment;
        logic [SEG_W-1:0] second_segment;
    } key_t;

    typedef struct packed {
        key_t              key;
        logic [LEN_W-1:0]  path_length;
        logic [DIST_W-1:0] distance;
    } entry_t;

endpackage

// ===== rtl/spdc_match.sv =====
// Key comparator shared by every step of the entry walk.
module spdc_match (
    input  spdc_pkg::key_t   key,
    input  spdc_pkg::entry_t entry,
    input  logic             live,
    output logic             hit
);
    import spdc_pkg::*;

    assign hit = live
               && (entry.key.first_segment == key.first_segment)
               && (entry.key.second_segment == key.second_segment);

endmodule

// ===== rtl/segment_pair_distance_cache.sv =====
// Fully associative result cache keyed by segment pairs, walked one entry per cycle.
// Flush, unknown kinds and stored adds skip the walk; their result is registered from the response state.
// Lookups and invalidating adds walk the entry memory through its single read port,
// and a lookup stops at its first hit. One item at a time.
// Synchronous active-low reset clears the valid marks, the write pointer and the last
// path length and loads the threshold with 80.0; entry contents are not reset.
module segment_pair_distance_cache #(
    parameter int ENTRIES = spdc_pkg::ENTRIES_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [30:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [14:0] s_first_segment,
    input  logic [14:0] s_second_segment,
    input  logic [15:0] s_path_length_in,
    input  logic [31:0] s_distance_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_hit,
    output logic [31:0] m_distance_out,
    output logic [15:0] m_path_length_out
);
    import spdc_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_RESP} state_t;

    state_t              state_reg, state_next;
    logic [THR_W-1:0]    min_dist_reg, min_dist_next;
    logic [ENTRIES-1:0]  valid_reg, valid_next;
    logic [IDX_W-1:0]    wp_reg, wp_next;
    logic [LEN_W-1:0]    last_len_reg, last_len_next;
    key_t                key_reg, key_next;
    logic                lookup_reg, lookup_next;
    logic [CNT_W-1:0]    issue_reg, issue_next;
    logic [IDX_W-1:0]    chk_idx_reg, chk_idx_next;
    logic                chk_live_reg, chk_live_next;
    logic                res_hit_reg, res_hit_next;
    logic [DIST_W-1:0]   res_dist_reg, res_dist_next;
    logic                m_valid_reg, m_valid_next;
    logic                m_hit_reg, m_hit_next;
    logic [DIST_W-1:0]   m_dist_reg, m_dist_next;
    logic [LEN_W-1:0]    m_len_reg, m_len_next;

    entry_t              mem [ENTRIES];
    entry_t              rd_data_reg;
    entry_t              wr_entry;
    logic                mem_we;
    logic                rd_en;
    logic                store_add;
    logic                match;

    assign store_add = $signed(s_distance_in) > $signed({1'b0, min_dist_reg});

    assign wr_entry.key.first_segment  = s_first_segment;
    assign wr_entry.key.second_segment = s_second_segment;
    assign wr_entry.path_length        = s_path_length_in;
    assign wr_entry.distance           = s_distance_in;

    spdc_match u_match (
        .key   (key_reg),
        .entry (rd_data_reg),
        .live  (chk_live_reg && valid_reg[chk_idx_reg]),
        .hit   (match)
    );

    always_comb begin
        state_next    = state_reg;
        min_dist_next = cfg_wr_en ? cfg_wr_data : min_dist_reg;
        valid_next    = valid_reg;
        wp_next       = wp_reg;
        last_len_next = last_len_reg;
        key_next      = key_reg;
        lookup_next   = lookup_reg;
        issue_next    = issue_reg;
        chk_idx_next  = chk_idx_reg;
        chk_live_next = chk_live_reg;
        res_hit_next  = res_hit_reg;
        res_dist_next = res_dist_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_hit_next    = m_hit_reg;
        m_dist_next   = m_dist_reg;
        m_len_next    = m_len_reg;
        mem_we        = 1'b0;
        rd_en         = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    key_next.first_segment  = s_first_segment;
                    key_next.second_segment = s_second_segment;
                    lookup_next   = (s_kind == KIND_LOOKUP);
                    issue_next    = '0;
                    chk_live_next = 1'b0;
                    res_hit_next  = 1'b0;
                    res_dist_next = MISS_DISTANCE;
                    case (s_kind)
                        KIND_FLUSH: begin
                            valid_next = '0;
                            wp_next    = '0;
                            state_next = ST_RESP;
                        end
                        KIND_ADD: begin
                            if (store_add) begin
                                mem_we            = 1'b1;
                                valid_next[wp_reg] = 1'b1;
                                wp_next = (wp_reg == IDX_W'(ENTRIES - 1)) ? '0 : wp_reg + 1'b1;
                                last_len_next     = s_path_length_in;
                                state_next        = ST_RESP;
                            end else begin
                                state_next = ST_SCAN;
                            end
                        end
                        KIND_LOOKUP: begin
                            state_next = ST_SCAN;
                        end
                        default: begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                rd_en         = (issue_reg < CNT_W'(ENTRIES));
                chk_live_next = rd_en;
                chk_idx_next  = issue_reg[IDX_W-1:0];
                if (rd_en) begin
                    issue_next = issue_reg + 1'b1;
                end
                if (match) begin
                    if (lookup_reg) begin
                        res_hit_next  = 1'b1;
                        res_dist_next = rd_data_reg.distance;
                        last_len_next = rd_data_reg.path_length;
                        chk_live_next = 1'b0;
                        state_next    = ST_RESP;
                    end else begin
                        valid_next[chk_idx_reg] = 1'b0;
                    end
                end else if (!chk_live_reg && !rd_en) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_hit_next   = res_hit_reg;
                    m_dist_next  = res_dist_reg;
                    m_len_next   = last_len_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            min_dist_reg <= MIN_DIST_RESET;
            valid_reg    <= '0;
            wp_reg       <= '0;
            last_len_reg <= '0;
            issue_reg    <= '0;
            chk_live_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            min_dist_reg <= min_dist_next;
            valid_reg    <= valid_next;
            wp_reg       <= wp_next;
            last_len_reg <= last_len_next;
            issue_reg    <= issue_next;
            chk_live_reg <= chk_live_next;
            m_valid_reg  <= m_valid_next;
        end
        key_reg      <= key_next;
        lookup_reg   <= lookup_next;
        chk_idx_reg  <= chk_idx_next;
        res_hit_reg  <= res_hit_next;
        res_dist_reg <= res_dist_next;
        m_hit_reg    <= m_hit_next;
        m_dist_reg   <= m_dist_next;
        m_len_reg    <= m_len_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wp_reg] <= wr_entry;
        end
        if (rd_en) begin
            rd_data_reg <= mem[issue_reg[IDX_W-1:0]];
        end
    end

    assign s_ready           = (state_reg == ST_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_hit             = m_hit_reg;
    assign m_distance_out    = m_dist_reg;
    assign m_path_length_out = m_len_reg;

endmodule

// ===== rtl/spdc_checker.sv =====
// Port-level checks of the distance cache, bound to its top level.
module spdc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_hit,
    input logic [31:0] m_distance_out,
    input logic [15:0] m_path_length_out
);
    import spdc_pkg::*;

    // A result that is not taken holds its value.
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit) && $stable(m_distance_out)
                                && $stable(m_path_length_out))
        else $error("result changed while stalled");

    // The block works on one item at a time.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item accepted while busy");

    // A result without a hit carries the miss distance.
    a_miss_distance: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> m_distance_out == MISS_DISTANCE)
        else $error("miss with wrong distance");

    // Reset leaves the block empty and ready for an item.
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("wrong state after reset");

endmodule

bind segment_pair_distance_cache spdc_checker u_spdc_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_hit             (m_hit),
    .m_distance_out    (m_distance_out),
    .m_path_length_out (m_path_length_out)
);

// ===== test/segment_pair_distance_cache_tb.sv =====
// Self-checking testbench for the segment pair distance cache, with a scoreboard that models it.
`timescale 1ns / 1ps

module segment_pair_distance_cache_tb;
    import spdc_pkg::*;

    localparam int ENTRIES = ENTRIES_DEFAULT;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int KEY_POOL = 12;
    localparam int ITEMS_PER_PHASE = 265;
    localparam int SETTLE_CYCLES = ENTRIES + 8;
    localparam int QUIET_LIMIT = 4000;

    typedef struct packed {
        logic [1:0]        kind;
        key_t              key;
        logic [LEN_W-1:0]  path_length;
        logic [DIST_W-1:0] distance;
    } cache_item_t;

    typedef struct packed {
        logic              hit;
        logic [DIST_W-1:0] distance;
        logic [LEN_W-1:0]  path_length;
    } cache_outcome_t;

    class distance_cache_scoreboard;
        bit                entry_live [ENTRIES];
        key_t              entry_key [ENTRIES];
        logic [LEN_W-1:0]  entry_length [ENTRIES];
        logic [DIST_W-1:0] entry_dist [ENTRIES];
        int                fill_slot;
        logic [LEN_W-1:0]  recent_length;
        logic [THR_W-1:0]  threshold;
        cache_outcome_t    pending_outcomes [$];
        int mismatches, results_seen;
        int items, lookups, hits, stored_adds, dropping_adds, flushes;

        function new();
            foreach (entry_live[i]) entry_live[i] = 1'b0;
            fill_slot = 0;
            recent_length = '0;
            threshold = MIN_DIST_RESET;
            mismatches = 0;
            results_seen = 0;
            items = 0;
            lookups = 0;
            hits = 0;
            stored_adds = 0;
            dropping_adds = 0;
            flushes = 0;
        endfunction

        function void note_item(cache_item_t it);
            cache_outcome_t outcome;
            bit found;
            outcome.hit = 1'b0;
            outcome.distance = MISS_DISTANCE;
            found = 1'b0;
            items++;
            case (it.kind)
                KIND_FLUSH: begin
                    foreach (entry_live[i]) entry_live[i] = 1'b0;
                    fill_slot = 0;
                    flushes++;
                end
                KIND_ADD: begin
                    if ($signed(it.distance) > $signed({1'b0, threshold})) begin
                        entry_live[fill_slot] = 1'b1;
                        entry_key[fill_slot] = it.key;
                        entry_length[fill_slot] = it.path_length;
                        entry_dist[fill_slot] = it.distance;
                        fill_slot = (fill_slot + 1 >= ENTRIES) ? 0 : fill_slot + 1;
                        recent_length = it.path_length;
                        stored_adds++;
                    end else begin
                        foreach (entry_live[i])
                            if (entry_live[i] && entry_key[i] == it.key) entry_live[i] = 1'b0;
                        dropping_adds++;
                    end
                end
                KIND_LOOKUP: begin
                    lookups++;
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (!found && entry_live[i] && entry_key[i] == it.key) begin
                            found = 1'b1;
                            outcome.hit = 1'b1;
                            outcome.distance = entry_dist[i];
                            recent_length = entry_length[i];
                        end
                    end
                    if (found) hits++;
                end
                default: begin
                end
            endcase
            outcome.path_length = recent_length;
            pending_outcomes.push_back(outcome);
        endfunction

        function void check_outcome(cache_outcome_t seen);
            cache_outcome_t want;
            results_seen++;
            if (pending_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: result %0d arrived with nothing expected: ",
                              "hit %0b distance %h length %h"},
                             $time, results_seen, seen.hit, seen.distance, seen.path_length);
            end else begin
                want = pending_outcomes.pop_front();
                if (seen.hit !== want.hit || seen.distance !== want.distance ||
                    seen.path_length !== want.path_length) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"%0t: result %0d expected hit %0b distance %h length %h, ",
                                  "got hit %0b distance %h length %h"},
                                 $time, results_seen, want.hit, want.distance,
                                 want.path_length, seen.hit, seen.distance, seen.path_length);
                end
            end
        endfunction
    endclass

    logic              aclk;
    logic              aresetn = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [THR_W-1:0]  cfg_wr_data = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [1:0]        s_kind = KIND_FLUSH;
    logic [SEG_W-1:0]  s_first_segment = '0;
    logic [SEG_W-1:0]  s_second_segment = '0;
    logic [LEN_W-1:0]  s_path_length_in = '0;
    logic [DIST_W-1:0] s_distance_in = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_hit;
    logic [DIST_W-1:0] m_distance_out;
    logic [LEN_W-1:0]  m_path_length_out;

    distance_cache_scoreboard sb;
    key_t key_pool [KEY_POOL];
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int quiet_cycles = 0;
    int settings_used = 0;

    segment_pair_distance_cache #(.ENTRIES(ENTRIES)) uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (s_kind),
        .s_first_segment   (s_first_segment),
        .s_second_segment  (s_second_segment),
        .s_path_length_in  (s_path_length_in),
        .s_distance_in     (s_distance_in),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_hit             (m_hit),
        .m_distance_out    (m_distance_out),
        .m_path_length_out (m_path_length_out)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        cache_item_t seen_item;
        cache_outcome_t seen_outcome;
        if (aresetn && sb != null) begin
            if (s_valid && s_ready) begin
                seen_item.kind = s_kind;
                seen_item.key.first_segment = s_first_segment;
                seen_item.key.second_segment = s_second_segment;
                seen_item.path_length = s_path_length_in;
                seen_item.distance = s_distance_in;
                sb.note_item(seen_item);
            end
            if (m_valid && m_ready) begin
                seen_outcome.hit = m_hit;
                seen_outcome.distance = m_distance_out;
                seen_outcome.path_length = m_path_length_out;
                sb.check_outcome(seen_outcome);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Timed out after %0d cycles without a handshake.", QUIET_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic push_item(input cache_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= it.kind;
        s_first_segment <= it.key.first_segment;
        s_second_segment <= it.key.second_segment;
        s_path_length_in <= it.path_length;
        s_distance_in <= it.distance;
        @(posedge aclk);
        while (!(s_valid && s_ready)) @(posedge aclk);
    endtask

    task automatic send_op(input logic [1:0] kind, input logic [SEG_W-1:0] first,
                           input logic [SEG_W-1:0] second, input logic [LEN_W-1:0] len,
                           input logic [DIST_W-1:0] distance_val);
        cache_item_t it;
        it.kind = kind;
        it.key.first_segment = first;
        it.key.second_segment = second;
        it.path_length = len;
        it.distance = distance_val;
        push_item(it);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_outcomes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic program_threshold(input logic [THR_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.threshold = value;
        settings_used++;
        @(posedge aclk);
    endtask

    function automatic logic [DIST_W-1:0] pick_distance(input logic [THR_W-1:0] thr);
        logic [DIST_W-1:0] base;
        base = {1'b0, thr};
        case ($urandom_range(0, 9))
            0: return base;
            1: return base + 32'd1;
            2, 3, 4: return base + $urandom_range(1, 32'h000F_FFFF);
            5: return base - $urandom_range(0, 32'h000F_FFFF);
            6: return $urandom;
            7: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'hFFFF_FFFF;
                    default: return 32'h0000_0000;
                endcase
            end
            default: return base + $urandom;
        endcase
    endfunction

    task automatic send_random_item();
        cache_item_t it;
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 4) it.kind = KIND_FLUSH;
        else if (roll < 7) it.kind = KIND_UNUSED;
        else if (roll < 52) it.kind = KIND_ADD;
        else it.kind = KIND_LOOKUP;
        if ($urandom_range(0, 9) == 0) begin
            it.key.first_segment = SEG_W'($urandom);
            it.key.second_segment = SEG_W'($urandom);
        end else begin
            it.key = key_pool[$urandom_range(0, KEY_POOL - 1)];
        end
        if ($urandom_range(0, 9) == 0)
            it.path_length = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        else
            it.path_length = LEN_W'($urandom);
        it.distance = pick_distance(sb.threshold);
        push_item(it);
    endtask

    task automatic run_directed();
        send_op(KIND_LOOKUP, 15'd0, 15'd0, 16'd0, 32'd0);
        send_op(KIND_ADD, 15'd0, 15'd0, 16'hFFFF, 32'h0050_0001);
        send_op(KIND_ADD, 15'h7FFF, 15'h7FFF, 16'h0000, 32'h7FFF_FFFF);
        send_op(KIND_ADD, 15'd0, 15'h7FFF, 16'd1234, 32'h0050_0000);
        send_op(KIND_ADD, 15'h7FFF, 15'd0, 16'd77, 32'h8000_0000);
        send_op(KIND_LOOKUP, 15'd0, 15'd0, 16'd0, 32'd0);
        send_op(KIND_LOOKUP, 15'h7FFF, 15'h7FFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_op(KIND_LOOKUP, 15'h7FFF, 15'd0, 16'd0, 32'd0);
        send_op(KIND_ADD, 15'h7FFF, 15'd0, 16'h5555, 32'h1234_5678);
        send_op(KIND_ADD, 15'd0, 15'h7FFF, 16'hAAAA, 32'h0050_0001);
        send_op(KIND_LOOKUP, 15'd0, 15'h7FFF, 16'd0, 32'd0);
        send_op(KIND_LOOKUP, 15'h7FFF, 15'd0, 16'd0, 32'd0);
        send_op(KIND_ADD, 15'd0, 15'd0, 16'h0F0F, 32'h0100_0000);
        send_op(KIND_LOOKUP, 15'd0, 15'd0, 16'd0, 32'd0);
        send_op(KIND_ADD, 15'd0, 15'd0, 16'h1111, 32'h0000_0000);
        send_op(KIND_LOOKUP, 15'd0, 15'd0, 16'd0, 32'd0);
        send_op(KIND_UNUSED, 15'h7FFF, 15'h7FFF, 16'hFFFF, 32'h7FFF_FFFF);
        send_op(KIND_LOOKUP, 15'h7FFF, 15'h7FFF, 16'd0, 32'd0);
        for (int i = 0; i < 5; i++)
            send_op(KIND_ADD, 15'(i + 100), 15'(i + 101), 16'(i + 1), 32'h0200_0000 + 32'(i));
        send_op(KIND_LOOKUP, 15'h7FFF, 15'h7FFF, 16'd0, 32'd0);
        send_op(KIND_FLUSH, 15'd0, 15'd0, 16'd0, 32'd0);
        send_op(KIND_LOOKUP, 15'h7FFF, 15'd0, 16'd0, 32'd0);
        send_op(KIND_ADD, 15'd102, 15'd103, 16'h00FF, 32'h0300_0000);
        send_op(KIND_LOOKUP, 15'd102, 15'd103, 16'd0, 32'd0);
    endtask

    initial begin
        logic [THR_W-1:0] settings [6];
        sb = new();
        key_pool[0] = '{15'd0, 15'd0};
        key_pool[1] = '{15'h7FFF, 15'h7FFF};
        key_pool[2] = '{15'd0, 15'h7FFF};
        key_pool[3] = '{15'h7FFF, 15'd0};
        for (int i = 4; i < KEY_POOL; i += 2) begin
            key_pool[i].first_segment = SEG_W'($urandom);
            key_pool[i].second_segment = SEG_W'($urandom);
            key_pool[i + 1].first_segment = key_pool[i].second_segment;
            key_pool[i + 1].second_segment = key_pool[i].first_segment;
        end
        settings[0] = '0;
        settings[1] = '1;
        settings[2] = MIN_DIST_RESET;
        settings[3] = THR_W'($urandom);
        settings[4] = 31'd1;
        settings[5] = THR_W'($urandom_range(0, 32'h00FF_FFFF));

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 30;
        recv_idle_pct = 47;
        run_directed();
        drain_results();

        for (int phase = 0; phase < 6; phase++) begin
            send_idle_pct = (phase < 2) ? 30 : (phase < 4) ? 47 : 0;
            recv_idle_pct = (phase < 2) ? 47 : (phase < 4) ? 30 : 0;
            program_threshold(settings[phase]);
            repeat (ITEMS_PER_PHASE) send_random_item();
            drain_results();
        end

        sb.mismatches += sb.pending_outcomes.size();
        $display("Covered %0d items under %0d thresholds and three idling patterns.",
                 sb.items, settings_used + 1);
        $display({"Of these, %0d lookups (%0d hits), %0d stored adds, ",
                  "%0d dropping adds, %0d flushes."},
                 sb.lookups, sb.hits, sb.stored_adds, sb.dropping_adds, sb.flushes);
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== segment_pair_distance_cache.f =====
rtl/spdc_pkg.sv
rtl/spdc_match.sv
rtl/segment_pair_distance_cache.sv
rtl/spdc_checker.sv
test/segment_pair_distance_cache_tb.sv
